FILE: rtl/core/tli_pkg.sv
// Shared types and codes for the table linear interpolator.
package tli_pkg;

  // Operation codes carried by an input request.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Width of the entries-in-use register.
  localparam int unsigned CountW = 9;

  // Input request payload.
  typedef struct packed {
    logic               operation;
    logic [7:0]         entry_index;
    logic [31:0]        entry_energy;
    logic signed [31:0] entry_value;
    logic [31:0]        query_energy;
  } tli_in_t;

  // Result payload.
  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic               out_of_range;
  } tli_out_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic        is_query;
    logic        wr_en;
    logic [7:0]  idx;
    logic [31:0] energy;
    logic [31:0] value;
    logic [31:0] x;
  } tli_cmd_t;

endpackage

FILE: rtl/core/tli_front.sv
// Front end: accepts input requests, classifies them and queues commands.
module tli_front import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tli_in_t  in_data,
  output logic     q_valid,
  output tli_cmd_t q_cmd,
  input  logic     q_pop
);

  tli_cmd_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  tli_cmd_t   cmd_new;

  // Classify the request; writes beyond the table are dropped here.
  always_comb begin
    cmd_new.is_query = (in_data.operation == OP_QUERY);
    cmd_new.wr_en    = (in_data.operation == OP_WRITE) &&
                       (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
    cmd_new.idx      = in_data.entry_index;
    cmd_new.energy   = in_data.entry_energy;
    cmd_new.value    = in_data.entry_value;
    cmd_new.x        = in_data.query_energy;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping for the two-slot queue.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

FILE: rtl/core/tli_divider.sv
// Radix-2 restoring divider for a 65-bit dividend whose quotient fits in 33 bits.
module tli_divider import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [32:0] low_r, low_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // One quotient bit per cycle; quotient bits shift in behind the dividend.
  always_comb begin
    trial   = {rem_r, low_r[32]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[31:0] : trial[31:0];
    low_nxt = {low_r[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd33;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The upper dividend bits start as the partial remainder, already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[64:33];
      low_r <= dividend[32:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = low_r;

endmodule

FILE: rtl/core/tli_back.sv
// Back end: table memory, search sequencer, interpolation and result register.
module tli_back import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CountW-1:0] n_in_use,
  input  logic              q_valid,
  input  tli_cmd_t          q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tli_out_t          out_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FIRST = 13'b0000000000010,
    S_LAST  = 13'b0000000000100,
    S_PROBE = 13'b0000000001000,
    S_CMP   = 13'b0000000010000,
    S_RDA   = 13'b0000000100000,
    S_RDB   = 13'b0000001000000,
    S_RDC   = 13'b0000010000000,
    S_PREP  = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_START = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  logic [31:0] energy_mem [TABLE_DEPTH];
  logic [31:0] value_mem  [TABLE_DEPTH];

  state_t      state_r, state_nxt;
  logic [CountW-1:0] first_r, first_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] probe_r, probe_nxt;
  logic [CountW-1:0] rd_idx;
  logic [31:0] rd_e_r, rd_v_r;
  logic [31:0] x_r, e0_r, v0_r, vl_r, e1_r, v1_r, e2_r, v2_r;
  logic [31:0] de_r, dx_r;
  logic [32:0] mag_r;
  logic        neg_r;
  logic [64:0] prod_r;
  logic [31:0] res_r, res_nxt;
  logic        oor_r, oor_nxt;
  logic        mem_we;
  logic        out_valid_r;
  tli_out_t    out_data_r;
  logic        out_free;
  logic        out_load;
  logic        div_start;
  logic        div_done;
  logic [32:0] div_q;
  logic [32:0] dv;
  logic [31:0] de_c;

  assign out_free = !out_valid_r || !out_stall;
  assign de_c     = e2_r - e1_r;
  assign dv       = {v2_r[31], v2_r} - {v1_r[31], v1_r};

  // Sequencer: table writes, endpoint reads, binary search, then the interpolation step.
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    count_nxt = count_r;
    probe_nxt = probe_r;
    res_nxt   = res_r;
    oor_nxt   = oor_r;
    rd_idx    = '0;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_query) begin
            state_nxt = S_FIRST;
          end else begin
            mem_we = q_cmd.wr_en;
          end
        end
      end
      S_FIRST: begin
        rd_idx    = n_in_use - CountW'(1);
        state_nxt = S_LAST;
      end
      S_LAST: begin
        if ((x_r < e0_r) || (x_r > rd_e_r)) begin
          res_nxt   = '0;
          oor_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          oor_nxt   = 1'b0;
          first_nxt = '0;
          count_nxt = n_in_use;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (count_r == '0) begin
          if (first_r == '0) begin
            res_nxt   = v0_r;
            state_nxt = S_OUT;
          end else if (first_r >= n_in_use) begin
            res_nxt   = vl_r;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RDA;
          end
        end else begin
          probe_nxt = first_r + (count_r >> 1);
          rd_idx    = probe_nxt;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_e_r < x_r) begin
          first_nxt = probe_r + CountW'(1);
          count_nxt = count_r - (count_r >> 1) - CountW'(1);
        end else begin
          count_nxt = count_r >> 1;
        end
        state_nxt = S_PROBE;
      end
      S_RDA: begin
        rd_idx    = first_r - CountW'(1);
        state_nxt = S_RDB;
      end
      S_RDB: begin
        rd_idx    = first_r;
        state_nxt = S_RDC;
      end
      S_RDC: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        // A step that does not rise returns its lower value.
        if (e2_r <= e1_r) begin
          res_nxt   = v1_r;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = neg_r ? (v1_r - div_q[31:0]) : (v1_r + div_q[31:0]);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    count_r <= count_nxt;
    probe_r <= probe_nxt;
    res_r   <= res_nxt;
    oor_r   <= oor_nxt;
    if (state_r == S_IDLE && q_valid) begin
      x_r <= q_cmd.x;
    end
    if (state_r == S_FIRST) begin
      e0_r <= rd_e_r;
      v0_r <= rd_v_r;
    end
    if (state_r == S_LAST) begin
      vl_r <= rd_v_r;
    end
    if (state_r == S_RDB) begin
      e1_r <= rd_e_r;
      v1_r <= rd_v_r;
    end
    if (state_r == S_RDC) begin
      e2_r <= rd_e_r;
      v2_r <= rd_v_r;
    end
    if (state_r == S_PREP) begin
      // Clamp the offset into the step so the result stays between its ends.
      de_r  <= de_c;
      if (x_r <= e1_r) begin
        dx_r <= '0;
      end else if (x_r >= e2_r) begin
        dx_r <= de_c;
      end else begin
        dx_r <= x_r - e1_r;
      end
      neg_r <= dv[32];
      mag_r <= dv[32] ? (33'd0 - dv) : dv;
    end
    if (state_r == S_MUL) begin
      prod_r <= 65'(mag_r) * 65'(dx_r);
    end
    if (out_load) begin
      out_data_r.interpolated_value <= res_r;
      out_data_r.out_of_range       <= oor_r;
    end
  end

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      energy_mem[AW'(q_cmd.idx)] <= q_cmd.energy;
      value_mem[AW'(q_cmd.idx)]  <= q_cmd.value;
    end
    rd_e_r <= energy_mem[AW'(rd_idx)];
    rd_v_r <= value_mem[AW'(rd_idx)];
  end

  tli_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (de_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  // A loaded result is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

  // A probe is only compared while entries remain in the search window.
  a_cmp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (count_r != '0))
    else $error("probe compared with an empty search window");

  // The search never moves past the entries in use.
  a_first_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (first_r + count_r <= n_in_use))
    else $error("search window beyond entries in use");

endmodule

FILE: rtl/core/table_linear_interpolator_core.sv
// Top level of the table linear interpolator: config register, front and back ends.
//
// Usage: in_valid/in_stall carry one request of tli_in_t. A write request
// (operation 0) stores one (energy, value) entry and produces no result; a
// query (operation 1) produces one tli_out_t result on out_valid/out_stall.
// cfg_valid/cfg_ready write entries_in_use (9 bits); cfg_ready is always high.
// Write it only while the block is idle.
// A write is stored from the back end's idle state. A query reads the two
// endpoint entries; one outside the table goes straight to its result, while
// an in-range query runs a binary search of one read and one compare per probe
// (at most ceil(log2(n))+1 probes over n entries in use), ends the search,
// fetches the step, multiplies, starts and runs the 33-step bit-serial divide
// and loads the result, paced by the single read port and one-bit-per-cycle divider.
// A two-request queue lets requests arrive while a query is in progress.
// The result waits in an output register while out_stall is high; the back
// end then holds and the queue fills before in_stall rises.
// Reset (rst_n, synchronous) empties the queue, drops any pending result and
// sets entries_in_use to 1. Table contents are not cleared by reset.
module table_linear_interpolator_core import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tli_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tli_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data
);

  localparam int unsigned MaxN = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;

  logic [CountW-1:0] entries_r;
  logic [CountW-1:0] n_in_use;
  logic              q_valid;
  logic              q_pop;
  tli_cmd_t          q_cmd;

  assign cfg_ready = 1'b1;

  // Entries-in-use register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CountW'(1);
    end else if (cfg_valid && cfg_ready) begin
      entries_r <= cfg_data;
    end
  end

  // Zero counts as one entry; counts above the table depth are clamped.
  always_comb begin
    if (entries_r == '0) begin
      n_in_use = CountW'(1);
    end else if (entries_r > CountW'(MaxN)) begin
      n_in_use = CountW'(MaxN);
    end else begin
      n_in_use = entries_r;
    end
  end

  tli_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  tli_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_in_use  (n_in_use),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
